// ===== rtl/btcr_pkg.sv =====
// Shared constants, status codes and the CRC step function of the trial boot tracker.
package btcr_pkg;

	localparam int RECORD_BYTES_DEF = 24;
	localparam int CRC_SPAN         = 20;
	localparam int HDR_BYTES        = 24;

	localparam logic [31:0] CRC_POLY = 32'hedb88320;
	localparam logic [31:0] CRC_INIT = 32'hffffffff;

	localparam logic [7:0] MAGIC_0 = 8'h4d;
	localparam logic [7:0] MAGIC_1 = 8'h42;
	localparam logic [7:0] MAGIC_2 = 8'h54;
	localparam logic [7:0] MAGIC_3 = 8'h31;

	localparam logic [31:0] GRACE_RST     = 32'd60000;
	localparam logic [7:0]  FMT_VER_RST   = 8'd1;
	localparam logic [7:0]  CONF_CODE_RST = 8'd1;
	localparam logic [7:0]  REJ_CODE_RST  = 8'd2;

	localparam logic [1:0] REG_GRACE     = 2'd0;
	localparam logic [1:0] REG_FMT_VER   = 2'd1;
	localparam logic [1:0] REG_CONF_CODE = 2'd2;
	localparam logic [1:0] REG_REJ_CODE  = 2'd3;

	typedef logic [3:0] status_t;

	localparam status_t STS_OK          = 4'd0;
	localparam status_t STS_INVALID     = 4'd1;
	localparam status_t STS_BLOCKED     = 4'd2;
	localparam status_t STS_AUTH_FAIL   = 4'd3;
	localparam status_t STS_IDLE        = 4'd4;
	localparam status_t STS_PERSIST_ERR = 4'd5;
	localparam status_t STS_CONFIRMED   = 4'd6;
	localparam status_t STS_PENDING     = 4'd7;
	localparam status_t STS_ROLLBACK    = 4'd8;

	localparam logic KIND_BEGIN = 1'b0;
	localparam logic KIND_POLL  = 1'b1;

	// One reflected CRC-32 step over a whole byte.
	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] d);
		logic [31:0] r;
		r = c ^ {24'd0, d};
		for (int b = 0; b < 8; b++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

endpackage

// ===== rtl/boot_trial_confirm_rollback.sv =====
// Top level of the trial boot tracker with confirm or rollback.
// A begin item and a poll that emits no record give one status transaction, and the
// block is ready again once that transaction is registered at the output.
// A poll that emits a record gives RECORD_BYTES byte transactions and one status
// transaction, one per cycle while the output is not stalled; the byte sequencer
// feeds the first CRC_SPAN bytes, one a cycle, through the CRC unit.
// Reset restores the register defaults and clears the stored trial.
module boot_trial_confirm_rollback #(
	parameter int RECORD_BYTES = btcr_pkg::RECORD_BYTES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// try_slot, spare_slot, img_ver, min_ver, now_ms, auth_ok,
	// healthy, store_ok, zero fill
	input  logic [119:0] s_axis_tdata,
	// kind
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// status, record_byte, byte_valid, reboot_request, reboot_slot, zero fill
	output logic [15:0]  m_axis_tdata,
	output logic         m_axis_tlast,
	input  logic         cfg_wen,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int IDXW = $clog2(RECORD_BYTES);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_BYTES = 2'd1;
	localparam logic [1:0] ST_STAT  = 2'd2;

	logic [7:0]  try_slot;
	logic [7:0]  spare_slot;
	logic [31:0] img_ver;
	logic [31:0] min_ver;
	logic [31:0] now_ms;
	logic        auth_ok;
	logic        healthy;
	logic        store_ok;

	assign try_slot   = s_axis_tdata[7:0];
	assign spare_slot = s_axis_tdata[15:8];
	assign img_ver    = s_axis_tdata[47:16];
	assign min_ver    = s_axis_tdata[79:48];
	assign now_ms     = s_axis_tdata[111:80];
	assign auth_ok    = s_axis_tdata[112];
	assign healthy    = s_axis_tdata[113];
	assign store_ok   = s_axis_tdata[114];

	logic [31:0] grace_q;
	logic [7:0]  fmt_ver_q;
	logic [7:0]  conf_code_q;
	logic [7:0]  rej_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grace_q     <= btcr_pkg::GRACE_RST;
			fmt_ver_q   <= btcr_pkg::FMT_VER_RST;
			conf_code_q <= btcr_pkg::CONF_CODE_RST;
			rej_code_q  <= btcr_pkg::REJ_CODE_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				btcr_pkg::REG_GRACE:     grace_q     <= cfg_data;
				btcr_pkg::REG_FMT_VER:   fmt_ver_q   <= cfg_data[7:0];
				btcr_pkg::REG_CONF_CODE: conf_code_q <= cfg_data[7:0];
				btcr_pkg::REG_REJ_CODE:  rej_code_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Stored slots only ever hold 0 or 1, so one bit each suffices.
	logic        active_q;
	logic        tslot_q;
	logic        fslot_q;
	logic [31:0] iver_q;
	logic [31:0] start_q;

	logic [1:0]            state_q;
	logic [IDXW-1:0]       idx_q;
	btcr_pkg::status_t     stat_q;
	logic                  reboot_q;
	logic [7:0]            code_q;
	logic                  out_valid_q;
	logic [15:0]           out_data_q;
	logic                  out_last_q;

	logic        accept;
	logic        out_free;
	logic        pair_ok_in;
	logic        stored_ok;
	logic [31:0] deadline;
	logic        expired;
	logic [31:0] crc_val;
	logic        crc_init;
	logic        crc_en;
	logic [7:0]  rec [btcr_pkg::HDR_BYTES];
	logic [7:0]  byte_nxt;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	assign pair_ok_in = (try_slot[7:1] == 7'd0) && (spare_slot[7:1] == 7'd0)
		&& (try_slot[0] != spare_slot[0]);
	assign stored_ok  = (tslot_q != fslot_q);
	assign deadline   = start_q + grace_q;
	assign expired    = !(now_ms < deadline);

	always_comb begin
		rec[0]  = btcr_pkg::MAGIC_0;
		rec[1]  = btcr_pkg::MAGIC_1;
		rec[2]  = btcr_pkg::MAGIC_2;
		rec[3]  = btcr_pkg::MAGIC_3;
		rec[4]  = fmt_ver_q;
		rec[5]  = code_q;
		rec[6]  = {7'd0, tslot_q};
		rec[7]  = {7'd0, fslot_q};
		rec[8]  = iver_q[7:0];
		rec[9]  = iver_q[15:8];
		rec[10] = iver_q[23:16];
		rec[11] = iver_q[31:24];
		rec[12] = start_q[7:0];
		rec[13] = start_q[15:8];
		rec[14] = start_q[23:16];
		rec[15] = start_q[31:24];
		rec[16] = grace_q[7:0];
		rec[17] = grace_q[15:8];
		rec[18] = grace_q[23:16];
		rec[19] = grace_q[31:24];
		rec[20] = crc_val[7:0];
		rec[21] = crc_val[15:8];
		rec[22] = crc_val[23:16];
		rec[23] = crc_val[31:24];
	end

	assign byte_nxt = (idx_q < IDXW'(btcr_pkg::HDR_BYTES)) ? rec[idx_q[4:0]] : 8'd0;
	assign crc_init = (state_q == ST_IDLE);
	assign crc_en   = (state_q == ST_BYTES) && out_free
		&& (idx_q < IDXW'(btcr_pkg::CRC_SPAN));

	btcr_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.init   (crc_init),
		.en     (crc_en),
		.data   (byte_nxt),
		.crc    (crc_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			active_q    <= 1'b0;
			tslot_q     <= 1'b0;
			fslot_q     <= 1'b0;
			iver_q      <= '0;
			start_q     <= '0;
			idx_q       <= '0;
			stat_q      <= btcr_pkg::STS_OK;
			reboot_q    <= 1'b0;
			code_q      <= '0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					idx_q    <= '0;
					reboot_q <= 1'b0;
					if (accept) begin
						state_q <= ST_STAT;
						if (s_axis_tuser == btcr_pkg::KIND_BEGIN) begin
							if (!pair_ok_in) begin
								stat_q <= btcr_pkg::STS_INVALID;
							end else if (img_ver < min_ver) begin
								stat_q <= btcr_pkg::STS_BLOCKED;
							end else if (!auth_ok) begin
								stat_q <= btcr_pkg::STS_AUTH_FAIL;
							end else begin
								stat_q   <= btcr_pkg::STS_OK;
								tslot_q  <= try_slot[0];
								fslot_q  <= spare_slot[0];
								iver_q   <= img_ver;
								start_q  <= now_ms;
								active_q <= 1'b1;
							end
						end else if (!stored_ok) begin
							stat_q <= btcr_pkg::STS_INVALID;
						end else if (!active_q) begin
							stat_q <= btcr_pkg::STS_IDLE;
						end else if (healthy) begin
							state_q  <= ST_BYTES;
							code_q   <= conf_code_q;
							stat_q   <= store_ok ? btcr_pkg::STS_CONFIRMED
								: btcr_pkg::STS_PERSIST_ERR;
							active_q <= !store_ok;
						end else if (!expired) begin
							stat_q <= btcr_pkg::STS_PENDING;
						end else begin
							state_q  <= ST_BYTES;
							code_q   <= rej_code_q;
							stat_q   <= store_ok ? btcr_pkg::STS_ROLLBACK
								: btcr_pkg::STS_PERSIST_ERR;
							reboot_q <= store_ok;
							active_q <= !store_ok;
						end
					end
				end
				ST_BYTES: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_last_q  <= 1'b0;
						idx_q       <= idx_q + IDXW'(1);
						if (idx_q == IDXW'(RECORD_BYTES - 1)) begin
							state_q <= ST_STAT;
						end
					end
				end
				ST_STAT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_last_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == ST_BYTES) begin
				out_data_q <= {3'b000, 1'b1, byte_nxt, btcr_pkg::STS_OK};
			end else if (state_q == ST_STAT) begin
				out_data_q <= {1'b0, reboot_q & fslot_q, reboot_q, 1'b0, 8'd0, stat_q};
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

endmodule

// ===== rtl/btcr_crc.sv =====
// Byte-wise CRC-32 unit, reused for each checksummed byte of the record.
module btcr_crc (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        init,
	input  logic        en,
	input  logic [7:0]  data,
	output logic [31:0] crc
);

	logic [31:0] crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= btcr_pkg::CRC_INIT;
		end else if (init) begin
			crc_q <= btcr_pkg::CRC_INIT;
		end else if (en) begin
			crc_q <= btcr_pkg::crc_byte(crc_q, data);
		end
	end

	assign crc = ~crc_q;

endmodule

// ===== rtl/btcr_chk.sv =====
// Port-level checker of the trial boot tracker and its bind to the top level.
module btcr_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [15:0]  m_axis_tdata,
	input logic         m_axis_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast))
		else $error("Output transaction changed while stalled.");

	a_byte_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[12] |-> !m_axis_tlast
			&& m_axis_tdata[3:0] == btcr_pkg::STS_OK && m_axis_tdata[14:13] == 2'b00)
		else $error("Record byte transaction carries status fields.");

	a_status_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[12] && m_axis_tdata[11:4] == 8'd0)
		else $error("Status transaction carries a record byte.");

	a_reboot: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[13] |-> m_axis_tlast
			&& m_axis_tdata[3:0] == btcr_pkg::STS_ROLLBACK)
		else $error("Reboot requested outside a rollback status.");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[12] |-> !s_axis_tready)
		else $error("Input accepted while a record is being sent.");

endmodule

bind boot_trial_confirm_rollback btcr_chk u_btcr_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
